>>> rtl/core/bcd_pkg.sv
// shared types and constants for the click / double-click detector
// no dependencies; imported by bcd_if, bcd_fsm, the top level and the testbench
package bcd_pkg;

    localparam int unsigned NUM_KEYS = 4;
    localparam int unsigned KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam int unsigned KEY_W  = 2;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CODE_W = 2;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CFG_IW = 2;

    localparam logic [CNT_W-1:0] PRESS_LIMIT_RST = 16'h0800;
    localparam logic [CNT_W-1:0] GAP_LIMIT_RST   = 16'h0600;
    localparam logic             PRESSED_LVL_RST = 1'b0;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PRESS_LIMIT = 2'd0,
        CFG_GAP_LIMIT   = 2'd1,
        CFG_PRESSED_LVL = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_GAP    = 2'd2,
        PH_SECOND = 2'd3
    } phase_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2
    } event_t;

    // per-key entry: only the counter of the current phase is ever live
    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] ticks;
    } key_state_t;

    localparam int unsigned STATE_W = $bits(key_state_t);

    typedef struct packed {
        logic [CNT_W-1:0] press_limit;
        logic [CNT_W-1:0] gap_limit;
        logic             pressed_level;
    } cfg_t;

endpackage

>>> rtl/core/bcd_if.sv
// request and event channel interfaces with valid / ready handshake
// depends on bcd_pkg for field widths
interface bcd_key_if;
    import bcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic             key_level;

    modport source (output valid, output key_index, output key_level, input ready);
    modport sink (input valid, input key_index, input key_level, output ready);
endinterface

interface bcd_event_if;
    import bcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] event_code;
    logic [KEY_W-1:0]  event_key;

    modport source (output valid, output event_code, output event_key, input ready);
    modport sink (input valid, input event_code, input event_key, output ready);
endinterface

>>> rtl/core/bcd_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module bcd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/bcd_fsm.sv
// per-key phase update: one tick applied to one key entry
// depends on bcd_pkg
module bcd_fsm
    import bcd_pkg::*;
(
    input  key_state_t cur,
    input  logic       pressed,
    input  cfg_t       cfg,
    output key_state_t nxt,
    output event_t     ev
);

    logic [CNT_W-1:0] ticks_inc;

    // saturating tick counter
    assign ticks_inc = (cur.ticks == '1) ? cur.ticks : cur.ticks + CNT_W'(1);

    always_comb
    begin
        nxt = cur;
        ev  = EV_NONE;
        unique case (cur.phase)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    nxt.phase = PH_FIRST;
                    nxt.ticks = '0;
                end
            end
            PH_FIRST:
            begin
                if (pressed)
                begin
                    nxt.ticks = ticks_inc;
                end
                else if (cur.ticks > cfg.press_limit)
                begin
                    nxt.phase = PH_IDLE;
                    nxt.ticks = '0;
                end
                else
                begin
                    nxt.phase = PH_GAP;
                    nxt.ticks = '0;
                end
            end
            PH_GAP:
            begin
                if (pressed)
                begin
                    nxt.phase = PH_SECOND;
                    nxt.ticks = '0;
                end
                else if (ticks_inc > cfg.gap_limit)
                begin
                    nxt.phase = PH_IDLE;
                    nxt.ticks = '0;
                    ev        = EV_CLICK;
                end
                else
                begin
                    nxt.ticks = ticks_inc;
                end
            end
            PH_SECOND:
            begin
                if (pressed)
                begin
                    nxt.ticks = ticks_inc;
                end
                else
                begin
                    nxt.phase = PH_IDLE;
                    nxt.ticks = '0;
                    if (!(cur.ticks > cfg.press_limit))
                    begin
                        ev = EV_DOUBLE;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> rtl/core/button_click_double_click_detector_core.sv
// top level of the click / double-click detector
// depends on bcd_pkg, bcd_if, bcd_ram and bcd_fsm
//
// Takes one scan tick per clock (key index and raw pin level) unless the
// event output stalls, and returns exactly one event per tick: none,
// single click or double click, tagged with the key, from an output
// register. Per-key state lives in a small RAM with one read and one
// write port; a tick for the same key as the one just before it takes
// its state from a forwarding register instead of the RAM read. Keys
// start idle after reset through per-entry valid flags, so no clearing
// pass is needed. Configuration writes must be made while idle.
module button_click_double_click_detector_core
    import bcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    bcd_key_if.sink              key_in,
    bcd_event_if.source          event_out
);

    cfg_t cfg_reg;

    logic                s1_valid_reg;
    logic [KEY_W-1:0]    s1_key_reg;
    logic                s1_level_reg;
    logic                fwd_reg;
    logic                fwd_next;
    key_state_t          fwd_state_reg;
    logic [NUM_KEYS-1:0] entry_valid_reg;

    logic                out_valid_reg;
    event_t              out_code_reg;
    logic [KEY_W-1:0]    out_key_reg;

    logic                accept;
    logic                s1_advance;
    logic                s1_inrange;
    logic [KEY_AW-1:0]   s1_addr;
    logic [KEY_AW-1:0]   in_addr;
    logic [STATE_W-1:0]  rd_data;
    key_state_t          cur_state;
    key_state_t          nxt_state;
    event_t              ev;
    logic                pressed;
    logic                ram_we;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || event_out.ready);
    assign key_in.ready = !s1_valid_reg || s1_advance;
    assign accept = key_in.valid && key_in.ready;

    assign in_addr    = KEY_AW'(key_in.key_index);
    assign s1_addr    = KEY_AW'(s1_key_reg);
    assign s1_inrange = (32'(s1_key_reg) < NUM_KEYS);
    assign ram_we     = s1_advance && s1_inrange;

    // the write of the item ahead lands on the same edge as this read
    assign fwd_next = s1_advance && s1_inrange && (s1_key_reg == key_in.key_index);

    bcd_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (nxt_state),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        priority if (fwd_reg)
        begin
            cur_state = fwd_state_reg;
        end
        else if (entry_valid_reg[s1_addr])
        begin
            cur_state = key_state_t'(rd_data);
        end
        else
        begin
            cur_state = '{phase: PH_IDLE, ticks: '0};
        end
    end

    assign pressed = (s1_level_reg == cfg_reg.pressed_level);

    bcd_fsm u_fsm (
        .cur     (cur_state),
        .pressed (pressed),
        .cfg     (cfg_reg),
        .nxt     (nxt_state),
        .ev      (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_limit   <= PRESS_LIMIT_RST;
            cfg_reg.gap_limit     <= GAP_LIMIT_RST;
            cfg_reg.pressed_level <= PRESSED_LVL_RST;
            s1_valid_reg          <= 1'b0;
            fwd_reg               <= 1'b0;
            entry_valid_reg       <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PRESS_LIMIT: cfg_reg.press_limit   <= cfg_data;
                    CFG_GAP_LIMIT:   cfg_reg.gap_limit     <= cfg_data;
                    CFG_PRESSED_LVL: cfg_reg.pressed_level <= cfg_data[0];
                    default:         cfg_reg <= cfg_reg;
                endcase
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= fwd_next;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                entry_valid_reg[s1_addr] <= 1'b1;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (event_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg    <= key_in.key_index;
            s1_level_reg  <= key_in.key_level;
            fwd_state_reg <= nxt_state;
        end
        if (s1_advance)
        begin
            out_code_reg <= s1_inrange ? ev : EV_NONE;
            out_key_reg  <= s1_key_reg;
        end
    end

    assign event_out.valid      = out_valid_reg;
    assign event_out.event_code = out_code_reg;
    assign event_out.event_key  = out_key_reg;

endmodule

>>> test/button_click_double_click_detector_core_tb.sv
`timescale 1ns / 100ps
// testbench for button_click_double_click_detector_core: scan ticks in, click events out
// depends on bcd_pkg and the channel interfaces in bcd_if; self-checking against a local model
module button_click_double_click_detector_core_tb;
    import bcd_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int unsigned       WATCHDOG_LIMIT  = 4000;
    localparam int unsigned       PHASE_TICKS     = 228;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             level;
    } scan_tick_t;

    typedef struct packed {
        event_t           code;
        logic [KEY_W-1:0] key;
    } key_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IW-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    bcd_key_if   scan_bus ();
    bcd_event_if event_bus ();

    button_click_double_click_detector_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_in    (scan_bus),
        .event_out (event_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the detector: settings and per-key phase machines
    logic [CNT_W-1:0] press_limit = PRESS_LIMIT_RST;
    logic [CNT_W-1:0] gap_limit   = GAP_LIMIT_RST;
    logic             pressed_lvl = PRESSED_LVL_RST;
    phase_t           phase_of   [NUM_KEYS];
    logic [CNT_W-1:0] press_cnt  [NUM_KEYS];
    logic [CNT_W-1:0] gap_cnt    [NUM_KEYS];
    logic [CNT_W-1:0] second_cnt [NUM_KEYS];

    scan_tick_t  pending_ticks[$];
    key_event_t  expected_events[$];
    bit          gesture_bits[$];
    int unsigned queued_ticks = 0;
    int unsigned mismatches = 0;
    bit          idle_on = 1'b1;
    int unsigned send_gap = 0;
    int unsigned hold_cycles = 0;
    int unsigned quiet_cycles = 0;

    initial
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            phase_of[k]   = PH_IDLE;
            press_cnt[k]  = '0;
            gap_cnt[k]    = '0;
            second_cnt[k] = '0;
        end
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic event_t next_event(input logic [KEY_W-1:0] k, input logic lvl);
        event_t ev;
        logic   down;
        ev = EV_NONE;
        down = (lvl == pressed_lvl);
        if (k < NUM_KEYS)
        begin
            case (phase_of[k])
                PH_IDLE:
                    if (down)
                    begin
                        press_cnt[k] = '0;
                        phase_of[k] = PH_FIRST;
                    end
                PH_FIRST:
                    if (down)
                        press_cnt[k] = sat_inc(press_cnt[k]);
                    else if (press_cnt[k] > press_limit)
                        phase_of[k] = PH_IDLE;
                    else
                    begin
                        gap_cnt[k] = '0;
                        phase_of[k] = PH_GAP;
                    end
                PH_GAP:
                    if (down)
                    begin
                        second_cnt[k] = '0;
                        phase_of[k] = PH_SECOND;
                    end
                    else
                    begin
                        gap_cnt[k] = sat_inc(gap_cnt[k]);
                        if (gap_cnt[k] > gap_limit)
                        begin
                            phase_of[k] = PH_IDLE;
                            ev = EV_CLICK;
                        end
                    end
                default:
                    if (down)
                        second_cnt[k] = sat_inc(second_cnt[k]);
                    else
                    begin
                        if (!(second_cnt[k] > press_limit))
                            ev = EV_DOUBLE;
                        phase_of[k] = PH_IDLE;
                    end
            endcase
        end
        return ev;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int unsigned idle_len();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(posedge clk)
    begin : drive_scan
        scan_tick_t tick;
        key_event_t predicted;
        if (!rst_n)
        begin
            scan_bus.valid <= 1'b0;
            scan_bus.key_index <= '0;
            scan_bus.key_level <= 1'b0;
        end
        else
        begin
            if (scan_bus.valid && scan_bus.ready)
            begin
                predicted.code = next_event(scan_bus.key_index, scan_bus.key_level);
                predicted.key = scan_bus.key_index;
                expected_events.push_back(predicted);
            end
            if (!scan_bus.valid || scan_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    scan_bus.valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    tick = pending_ticks.pop_front();
                    scan_bus.valid <= 1'b1;
                    scan_bus.key_index <= tick.key;
                    scan_bus.key_level <= tick.level;
                    send_gap = idle_len();
                end
                else
                    scan_bus.valid <= 1'b0;
            end
        end
    end

    // event monitor with random backpressure
    always @(posedge clk)
    begin : watch_events
        key_event_t want;
        if (!rst_n)
            event_bus.ready <= 1'b0;
        else
        begin
            if (event_bus.valid && event_bus.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: event with nothing pending: code %0d key %0d",
                             $time, event_bus.event_code, event_bus.event_key);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_bus.event_code !== want.code || event_bus.event_key !== want.key)
                    begin
                        $display("%0t: event mismatch: expected code %0d key %0d, got code %0d key %0d",
                                 $time, want.code, want.key,
                                 event_bus.event_code, event_bus.event_key);
                        mismatches++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                event_bus.ready <= 1'b0;
            end
            else
            begin
                event_bus.ready <= 1'b1;
                hold_cycles = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((scan_bus.valid && scan_bus.ready) || (event_bus.valid && event_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic queue_tick(input logic [KEY_W-1:0] k, input bit down);
        scan_tick_t tick;
        tick.key = k;
        tick.level = down ? pressed_lvl : ~pressed_lvl;
        pending_ticks.push_back(tick);
        queued_ticks++;
    endtask

    // pattern of '1' (pressed) and '0' (released) ticks for one key
    task automatic queue_pattern(input logic [KEY_W-1:0] k, input string pat);
        for (int i = 0; i < pat.len(); i++)
            queue_tick(k, pat[i] == "1");
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || scan_bus.valid || expected_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_PRESS_LIMIT: press_limit = data;
            CFG_GAP_LIMIT:   gap_limit = data;
            CFG_PRESSED_LVL: pressed_lvl = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [CNT_W-1:0] plim, input logic [CNT_W-1:0] glim,
                              input logic lvl);
        logic [CFG_W-1:0] word;
        wait_drained();
        write_cfg(CFG_PRESS_LIMIT, plim);
        write_cfg(CFG_GAP_LIMIT, glim);
        // upper bits of the level word are don't-care
        word = CFG_W'($urandom);
        word[0] = lvl;
        write_cfg(CFG_PRESSED_LVL, word);
    endtask

    task automatic add_run(input bit down, input int unsigned n);
        repeat (n) gesture_bits.push_back(down);
    endtask

    function automatic int unsigned pick_upto(input int unsigned cap);
        return ($urandom_range(3) == 0) ? cap : $urandom_range(0, cap);
    endfunction

    function automatic int unsigned long_press_len();
        if (press_limit > 40)
            return $urandom_range(14, 40);
        return press_limit + 2 + $urandom_range(0, 3);
    endfunction

    // one gesture for one key, sized around the current limits
    task automatic build_gesture();
        int unsigned kind;
        int unsigned cap_p;
        int unsigned cap_g;
        gesture_bits.delete();
        cap_p = (press_limit > 12) ? 12 : press_limit;
        cap_g = (gap_limit > 12) ? 12 : gap_limit;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            add_run(1, 1 + pick_upto(cap_p));
            if (gap_limit > 40)
                add_run(0, $urandom_range(1, 20));
            else
                add_run(0, gap_limit + 2 + $urandom_range(0, 2));
        end
        else if (kind < 70)
        begin
            add_run(1, 1 + pick_upto(cap_p));
            add_run(0, 1 + pick_upto(cap_g));
            if ($urandom_range(3) == 0)
                add_run(1, long_press_len());
            else
                add_run(1, 1 + pick_upto(cap_p));
            add_run(0, $urandom_range(1, 3));
        end
        else if (kind < 82)
        begin
            add_run(1, long_press_len());
            add_run(0, $urandom_range(1, 4));
        end
        else
        begin
            repeat ($urandom_range(1, 6)) add_run(1'($urandom_range(1)), 1);
        end
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned      start;
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        bit               first_bits[$];
        start = queued_ticks;
        while (queued_ticks - start < n_items)
        begin
            ka = KEY_W'($urandom_range(NUM_KEYS - 1));
            build_gesture();
            if ($urandom_range(2) != 0)
            begin
                foreach (gesture_bits[i])
                    queue_tick(ka, gesture_bits[i]);
            end
            else
            begin
                // two keys scanned in a random interleave
                first_bits = gesture_bits;
                kb = ka + KEY_W'($urandom_range(1, NUM_KEYS - 1));
                build_gesture();
                while (first_bits.size() != 0 || gesture_bits.size() != 0)
                begin
                    if (gesture_bits.size() == 0 || (first_bits.size() != 0 && $urandom_range(1)))
                        queue_tick(ka, first_bits.pop_front());
                    else
                        queue_tick(kb, gesture_bits.pop_front());
                end
            end
        end
    endtask

    initial
    begin
        scan_bus.valid = 1'b0;
        scan_bus.key_index = '0;
        scan_bus.key_level = 1'b0;
        event_bus.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: double click on key 0, key 3 left waiting in its gap
        queue_pattern(0, "11010");
        queue_pattern(3, "100");

        // zero limits, active high
        set_config('0, '0, 1'b1);
        write_cfg(CFG_SPARE_INDEX, '1);
        queue_pattern(1, "100");
        queue_pattern(2, "110");
        queue_pattern(0, "10110");
        queue_pattern(3, "0");

        // both limits at max: any press is valid, the gap never times out
        set_config('1, '1, 1'b0);
        queue_pattern(1, "1110010");
        queue_pattern(2, "10");

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config('0, '0, 1'b0);
                1: set_config(16'd2, 16'd3, 1'b1);
                2: set_config('1, 16'd4, 1'b0);
                3: set_config(16'd5, '1, 1'b1);
                default: set_config(CNT_W'($urandom_range(0, 12)), CNT_W'($urandom_range(0, 12)),
                                    1'($urandom_range(1)));
            endcase
            idle_on = (p % 3 != 2);
            random_phase(PHASE_TICKS);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $display("%0t: %0d events never arrived", $time, expected_events.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
